// ===== sv/scc_pkg.sv =====
// shared types and constants for the strongly connected component counter
`default_nettype none
package scc_pkg;

    localparam int DEF_MAX_NODES = 1024;
    localparam int DEF_MAX_EDGES = 4096;
    localparam int FIELD_W       = 11;
    localparam int APB_DW        = 32;
    localparam int APB_AW        = 3;

    localparam logic CFG_NODE_COUNT = 1'b0;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLR_OFF,
        ST_CNT_RD,
        ST_CNT_OFF,
        ST_CNT_WR,
        ST_SUM_RD,
        ST_SUM_WR,
        ST_FILL_RD,
        ST_FILL_CUR,
        ST_FILL_WR,
        ST_VCLR,
        ST_OUT_RD,
        ST_OUT_FIN,
        ST_OUT_FDAT,
        ST_OUT_CHK,
        ST_NEXT,
        ST_START,
        ST_OFF1,
        ST_OFF2,
        ST_STEP,
        ST_NBR,
        ST_VIS,
        ST_POP1,
        ST_POP2,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               valid;
        logic [FIELD_W-1:0] count;
        logic               dropped;
    } res_t;

endpackage
`default_nettype wire

// ===== sv/scc_ram.sv =====
// simple dual-port synchronous ram, registered read
`default_nettype none
module scc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== sv/scc_core.sv =====
// edge store, adjacency build and two depth-first walks over memories
`default_nettype none
module scc_core #(
    parameter int MAX_NODES = scc_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = scc_pkg::DEF_MAX_EDGES,
    localparam int NCW = $clog2(MAX_NODES + 1)
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [NCW-1:0]              n_eff,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_has_edge,
    input  wire logic [scc_pkg::FIELD_W-1:0] s_edge_source,
    input  wire logic [scc_pkg::FIELD_W-1:0] s_edge_target,
    input  wire logic                        s_last_edge,
    output scc_pkg::res_t                    res,
    input  wire logic                        res_take
);
    localparam int NW  = $clog2(MAX_NODES);
    localparam int OAW = $clog2(MAX_NODES + 1);
    localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int SW  = NW + ECW;
    localparam int FW  = scc_pkg::FIELD_W;

    scc_pkg::state_t state_reg, state_next;

    logic           dir_reg;
    logic [ECW-1:0] held_reg;
    logic           drop_reg;
    logic [NCW-1:0] n_reg;
    logic [ECW-1:0] e_reg;
    logic [NCW-1:0] v_reg;
    logic [ECW-1:0] acc_reg;
    logic [NW-1:0]  key_reg;
    logic [NW-1:0]  val_reg;
    logic [NW-1:0]  w_reg;
    logic [NW-1:0]  cand_reg;
    logic [NW-1:0]  top_node_reg;
    logic [ECW-1:0] top_cur_reg;
    logic [ECW-1:0] top_end_reg;
    logic [NCW-1:0] sp_reg;
    logic [NCW-1:0] fin_reg;
    logic [FW-1:0]  count_reg;

    logic [NW-1:0]  ef_q, et_q, nbr0_q, nbr1_q, nbr_q, fin_q;
    logic [ECW-1:0] off0_q, off1_q, off_q, cur_q;
    logic           vis_q;
    logic [SW-1:0]  stk_q;

    logic [NW-1:0]  key_now, val_now, stk_node;
    logic [ECW-1:0] stk_cur;
    logic           ok_now, accept, ld_ok, more_edges, pop_last;

    logic           ld_we;
    logic           off_we;
    logic [OAW-1:0] off_waddr, off_raddr;
    logic [ECW-1:0] off_wdata;
    logic           cur_we;
    logic [NW-1:0]  cur_waddr, cur_raddr;
    logic [ECW-1:0] cur_wdata;
    logic           nbr_we;
    logic           vis_we, vis_wdata;
    logic [NW-1:0]  vis_waddr, vis_raddr;
    logic           fin_we;
    logic [NW-1:0]  fin_raddr;
    logic           stk_we;

    assign key_now    = dir_reg ? et_q : ef_q;
    assign val_now    = dir_reg ? ef_q : et_q;
    assign ok_now     = (NCW'(key_now) < n_reg) && (NCW'(val_now) < n_reg);
    assign off_q      = dir_reg ? off1_q : off0_q;
    assign nbr_q      = dir_reg ? nbr1_q : nbr0_q;
    assign stk_node   = stk_q[SW-1:ECW];
    assign stk_cur    = stk_q[ECW-1:0];
    assign more_edges = (top_cur_reg < top_end_reg);
    assign pop_last   = (sp_reg == NCW'(1));

    assign s_ready = (state_reg == scc_pkg::ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign ld_ok   = s_has_edge && (s_edge_source != '0) && (s_edge_target != '0)
                     && (32'(s_edge_source) <= 32'(n_eff))
                     && (32'(s_edge_target) <= 32'(n_eff))
                     && (held_reg < ECW'(MAX_EDGES));

    assign res.valid   = (state_reg == scc_pkg::ST_DONE);
    assign res.count   = count_reg;
    assign res.dropped = drop_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            scc_pkg::ST_IDLE:     if (accept && s_last_edge) state_next = scc_pkg::ST_CLR_OFF;
            scc_pkg::ST_CLR_OFF:  if (v_reg == n_reg) state_next = scc_pkg::ST_CNT_RD;
            scc_pkg::ST_CNT_RD:   state_next = (e_reg == held_reg) ? scc_pkg::ST_SUM_RD
                                                                   : scc_pkg::ST_CNT_OFF;
            scc_pkg::ST_CNT_OFF:  state_next = ok_now ? scc_pkg::ST_CNT_WR : scc_pkg::ST_CNT_RD;
            scc_pkg::ST_CNT_WR:   state_next = scc_pkg::ST_CNT_RD;
            scc_pkg::ST_SUM_RD:   state_next = (v_reg > n_reg) ? scc_pkg::ST_FILL_RD
                                                               : scc_pkg::ST_SUM_WR;
            scc_pkg::ST_SUM_WR:   state_next = scc_pkg::ST_SUM_RD;
            scc_pkg::ST_FILL_RD: begin
                if (e_reg == held_reg) begin
                    state_next = dir_reg ? scc_pkg::ST_VCLR : scc_pkg::ST_CLR_OFF;
                end else begin
                    state_next = scc_pkg::ST_FILL_CUR;
                end
            end
            scc_pkg::ST_FILL_CUR: state_next = ok_now ? scc_pkg::ST_FILL_WR : scc_pkg::ST_FILL_RD;
            scc_pkg::ST_FILL_WR:  state_next = scc_pkg::ST_FILL_RD;
            scc_pkg::ST_VCLR: begin
                if (v_reg == n_reg) begin
                    state_next = dir_reg ? scc_pkg::ST_OUT_FIN : scc_pkg::ST_OUT_RD;
                end
            end
            scc_pkg::ST_OUT_RD:   state_next = (v_reg == n_reg) ? scc_pkg::ST_VCLR
                                                                : scc_pkg::ST_OUT_CHK;
            scc_pkg::ST_OUT_FIN:  state_next = (fin_reg == '0) ? scc_pkg::ST_DONE
                                                               : scc_pkg::ST_OUT_FDAT;
            scc_pkg::ST_OUT_FDAT: state_next = scc_pkg::ST_OUT_CHK;
            scc_pkg::ST_OUT_CHK:  state_next = vis_q ? scc_pkg::ST_NEXT : scc_pkg::ST_START;
            scc_pkg::ST_NEXT:     state_next = dir_reg ? scc_pkg::ST_OUT_FIN : scc_pkg::ST_OUT_RD;
            scc_pkg::ST_START:    state_next = scc_pkg::ST_OFF1;
            scc_pkg::ST_OFF1:     state_next = scc_pkg::ST_OFF2;
            scc_pkg::ST_OFF2:     state_next = scc_pkg::ST_STEP;
            scc_pkg::ST_STEP: begin
                if (more_edges) begin
                    state_next = scc_pkg::ST_NBR;
                end else begin
                    state_next = pop_last ? scc_pkg::ST_NEXT : scc_pkg::ST_POP1;
                end
            end
            scc_pkg::ST_NBR:      state_next = scc_pkg::ST_VIS;
            scc_pkg::ST_VIS:      state_next = vis_q ? scc_pkg::ST_STEP : scc_pkg::ST_OFF1;
            scc_pkg::ST_POP1:     state_next = scc_pkg::ST_POP2;
            scc_pkg::ST_POP2:     state_next = scc_pkg::ST_STEP;
            scc_pkg::ST_DONE:     if (res_take) state_next = scc_pkg::ST_IDLE;
            default:              state_next = scc_pkg::ST_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        ld_we     = 1'b0;
        off_we    = 1'b0;
        off_waddr = OAW'(v_reg);
        off_wdata = '0;
        off_raddr = OAW'(v_reg);
        cur_we    = 1'b0;
        cur_waddr = key_reg;
        cur_wdata = cur_q + ECW'(1);
        cur_raddr = key_now;
        nbr_we    = 1'b0;
        vis_we    = 1'b0;
        vis_waddr = w_reg;
        vis_wdata = 1'b1;
        vis_raddr = NW'(v_reg);
        fin_we    = 1'b0;
        fin_raddr = NW'(fin_reg - NCW'(1));
        stk_we    = 1'b0;
        case (state_reg)
            scc_pkg::ST_IDLE:     ld_we = accept && ld_ok;
            scc_pkg::ST_CLR_OFF:  off_we = 1'b1;
            scc_pkg::ST_CNT_OFF:  off_raddr = OAW'(key_now) + OAW'(1);
            scc_pkg::ST_CNT_WR: begin
                off_we    = 1'b1;
                off_waddr = OAW'(key_reg) + OAW'(1);
                off_wdata = off_q + ECW'(1);
            end
            scc_pkg::ST_SUM_WR: begin
                off_we    = 1'b1;
                off_wdata = acc_reg + off_q;
                cur_we    = 1'b1;
                cur_waddr = NW'(v_reg - NCW'(1));
                cur_wdata = acc_reg;
            end
            scc_pkg::ST_FILL_WR: begin
                nbr_we = 1'b1;
                cur_we = 1'b1;
            end
            scc_pkg::ST_VCLR: begin
                vis_we    = (v_reg != n_reg);
                vis_waddr = NW'(v_reg);
                vis_wdata = 1'b0;
            end
            scc_pkg::ST_OUT_FDAT: vis_raddr = fin_q;
            scc_pkg::ST_START: begin
                vis_we    = 1'b1;
                off_raddr = OAW'(w_reg);
            end
            scc_pkg::ST_OFF1:     off_raddr = OAW'(w_reg) + OAW'(1);
            scc_pkg::ST_STEP:     fin_we = !more_edges && !dir_reg;
            scc_pkg::ST_NBR:      vis_raddr = nbr_q;
            scc_pkg::ST_VIS: begin
                vis_we    = !vis_q;
                stk_we    = !vis_q;
                off_raddr = OAW'(w_reg);
            end
            scc_pkg::ST_POP1:     off_raddr = OAW'(stk_node) + OAW'(1);
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= scc_pkg::ST_IDLE;
            held_reg  <= '0;
            drop_reg  <= 1'b0;
            dir_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                scc_pkg::ST_IDLE: begin
                    if (accept) begin
                        if (ld_ok) begin
                            held_reg <= held_reg + ECW'(1);
                        end else if (s_has_edge) begin
                            drop_reg <= 1'b1;
                        end
                        if (s_last_edge) begin
                            dir_reg <= 1'b0;
                        end
                    end
                end
                scc_pkg::ST_FILL_RD: if (e_reg == held_reg) dir_reg <= !dir_reg;
                scc_pkg::ST_OUT_RD:  if (v_reg == n_reg) dir_reg <= 1'b1;
                scc_pkg::ST_DONE: begin
                    if (res_take) begin
                        held_reg <= '0;
                        drop_reg <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // walk datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            scc_pkg::ST_IDLE: begin
                n_reg     <= n_eff;
                v_reg     <= '0;
                count_reg <= '0;
            end
            scc_pkg::ST_CLR_OFF: begin
                if (v_reg == n_reg) begin
                    e_reg <= '0;
                end else begin
                    v_reg <= v_reg + NCW'(1);
                end
            end
            scc_pkg::ST_CNT_RD: begin
                v_reg   <= NCW'(1);
                acc_reg <= '0;
            end
            scc_pkg::ST_CNT_OFF: begin
                key_reg <= key_now;
                if (!ok_now) e_reg <= e_reg + ECW'(1);
            end
            scc_pkg::ST_CNT_WR:  e_reg <= e_reg + ECW'(1);
            scc_pkg::ST_SUM_RD:  e_reg <= '0;
            scc_pkg::ST_SUM_WR: begin
                acc_reg <= acc_reg + off_q;
                v_reg   <= v_reg + NCW'(1);
            end
            scc_pkg::ST_FILL_RD: begin
                v_reg   <= '0;
                fin_reg <= '0;
            end
            scc_pkg::ST_FILL_CUR: begin
                key_reg <= key_now;
                val_reg <= val_now;
                if (!ok_now) e_reg <= e_reg + ECW'(1);
            end
            scc_pkg::ST_FILL_WR: e_reg <= e_reg + ECW'(1);
            scc_pkg::ST_VCLR: begin
                if (v_reg == n_reg) begin
                    v_reg <= '0;
                end else begin
                    v_reg <= v_reg + NCW'(1);
                end
            end
            scc_pkg::ST_OUT_RD: begin
                cand_reg <= NW'(v_reg);
                if (v_reg == n_reg) v_reg <= '0;
            end
            scc_pkg::ST_OUT_FIN: if (fin_reg != '0) fin_reg <= fin_reg - NCW'(1);
            scc_pkg::ST_OUT_FDAT: cand_reg <= fin_q;
            scc_pkg::ST_OUT_CHK: begin
                w_reg  <= cand_reg;
                sp_reg <= '0;
                if (!vis_q && dir_reg) count_reg <= count_reg + FW'(1);
            end
            scc_pkg::ST_NEXT:    if (!dir_reg) v_reg <= v_reg + NCW'(1);
            scc_pkg::ST_OFF1:    top_cur_reg <= off_q;
            scc_pkg::ST_OFF2: begin
                top_end_reg  <= off_q;
                top_node_reg <= w_reg;
                sp_reg       <= sp_reg + NCW'(1);
            end
            scc_pkg::ST_STEP: begin
                if (more_edges) begin
                    top_cur_reg <= top_cur_reg + ECW'(1);
                end else begin
                    if (!dir_reg) fin_reg <= fin_reg + NCW'(1);
                    sp_reg <= sp_reg - NCW'(1);
                end
            end
            scc_pkg::ST_NBR:     w_reg <= nbr_q;
            scc_pkg::ST_POP1: begin
                top_node_reg <= stk_node;
                top_cur_reg  <= stk_cur;
            end
            scc_pkg::ST_POP2:    top_end_reg <= off_q;
            default: begin
            end
        endcase
    end

    scc_ram #(.WIDTH(NW), .DEPTH(MAX_EDGES)) u_edge_from (
        .aclk(aclk), .we(ld_we), .waddr(held_reg[EW-1:0]),
        .wdata(NW'(s_edge_source - FW'(1))), .raddr(e_reg[EW-1:0]), .rdata(ef_q)
    );
    scc_ram #(.WIDTH(NW), .DEPTH(MAX_EDGES)) u_edge_to (
        .aclk(aclk), .we(ld_we), .waddr(held_reg[EW-1:0]),
        .wdata(NW'(s_edge_target - FW'(1))), .raddr(e_reg[EW-1:0]), .rdata(et_q)
    );
    scc_ram #(.WIDTH(ECW), .DEPTH(MAX_NODES + 1)) u_fwd_off (
        .aclk(aclk), .we(off_we && !dir_reg), .waddr(off_waddr),
        .wdata(off_wdata), .raddr(off_raddr), .rdata(off0_q)
    );
    scc_ram #(.WIDTH(ECW), .DEPTH(MAX_NODES + 1)) u_rev_off (
        .aclk(aclk), .we(off_we && dir_reg), .waddr(off_waddr),
        .wdata(off_wdata), .raddr(off_raddr), .rdata(off1_q)
    );
    scc_ram #(.WIDTH(NW), .DEPTH(MAX_EDGES)) u_fwd_nbr (
        .aclk(aclk), .we(nbr_we && !dir_reg), .waddr(cur_q[EW-1:0]),
        .wdata(val_reg), .raddr(top_cur_reg[EW-1:0]), .rdata(nbr0_q)
    );
    scc_ram #(.WIDTH(NW), .DEPTH(MAX_EDGES)) u_rev_nbr (
        .aclk(aclk), .we(nbr_we && dir_reg), .waddr(cur_q[EW-1:0]),
        .wdata(val_reg), .raddr(top_cur_reg[EW-1:0]), .rdata(nbr1_q)
    );
    scc_ram #(.WIDTH(ECW), .DEPTH(MAX_NODES)) u_cursor (
        .aclk(aclk), .we(cur_we), .waddr(cur_waddr),
        .wdata(cur_wdata), .raddr(cur_raddr), .rdata(cur_q)
    );
    scc_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_visit (
        .aclk(aclk), .we(vis_we), .waddr(vis_waddr),
        .wdata(vis_wdata), .raddr(vis_raddr), .rdata(vis_q)
    );
    scc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_finish (
        .aclk(aclk), .we(fin_we), .waddr(NW'(fin_reg)),
        .wdata(top_node_reg), .raddr(fin_raddr), .rdata(fin_q)
    );
    scc_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_stack (
        .aclk(aclk), .we(stk_we), .waddr(NW'(sp_reg - NCW'(1))),
        .wdata({top_node_reg, top_cur_reg}), .raddr(NW'(sp_reg - NCW'(2))), .rdata(stk_q)
    );
endmodule
`default_nettype wire

// ===== sv/scc_count_kosaraju.sv =====
// strongly connected component counter, top level
//
// input channel s_*: one directed edge per transfer (s_has_edge, s_edge_source,
// s_edge_target), nodes numbered from one; s_last_edge closes the graph. an edge
// with an endpoint outside 1..node_count (node_count capped at MAX_NODES), or one
// that arrives with the edge store full, is dropped and flagged in m_edge_dropped.
// edges load at one per cycle. after the last transfer s_ready stays low while the
// block builds forward and reverse adjacency lists in memory and runs two
// depth-first walks with a stack in memory; every memory read is registered.
// result channel m_*: one transfer carrying m_component_count and m_edge_dropped,
// held in an output register; the block waits while the receiver stalls and
// returns to loading once the result is taken by the register.
// the user must write node_count (apb, byte address 0) only while idle; the block
// does not enforce it. reset: synchronous, active low; node_count returns to one,
// no stored edges, no pending result; no memory clearing pass is needed after it.
`default_nettype none
module scc_count_kosaraju #(
    parameter int MAX_NODES = scc_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = scc_pkg::DEF_MAX_EDGES
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [scc_pkg::APB_AW-1:0]   paddr,
    input  wire logic [scc_pkg::APB_DW-1:0]   pwdata,
    output logic      [scc_pkg::APB_DW-1:0]   prdata,
    output logic                              pready,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_has_edge,
    input  wire logic [scc_pkg::FIELD_W-1:0]  s_edge_source,
    input  wire logic [scc_pkg::FIELD_W-1:0]  s_edge_target,
    input  wire logic                         s_last_edge,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [scc_pkg::FIELD_W-1:0]  m_component_count,
    output logic                              m_edge_dropped
);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int FW  = scc_pkg::FIELD_W;

    logic [FW-1:0]  node_count_reg;
    logic [NCW-1:0] n_eff;
    logic           reg_sel;
    logic           m_valid_reg;
    logic [FW-1:0]  count_reg;
    logic           dropped_reg;
    logic           res_take;
    scc_pkg::res_t  res;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == scc_pkg::CFG_NODE_COUNT);
    assign prdata  = reg_sel ? scc_pkg::APB_DW'(node_count_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= FW'(1);
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            node_count_reg <= pwdata[FW-1:0];
        end
    end

    // cap at the node capacity
    assign n_eff = (32'(node_count_reg) > 32'(MAX_NODES)) ? NCW'(MAX_NODES)
                                                         : NCW'(node_count_reg);

    assign res_take = res.valid && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take) begin
            count_reg   <= res.count;
            dropped_reg <= res.dropped;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_component_count = count_reg;
    assign m_edge_dropped    = dropped_reg;

    scc_core #(
        .MAX_NODES(MAX_NODES),
        .MAX_EDGES(MAX_EDGES)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .n_eff         (n_eff),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_has_edge    (s_has_edge),
        .s_edge_source (s_edge_source),
        .s_edge_target (s_edge_target),
        .s_last_edge   (s_last_edge),
        .res           (res),
        .res_take      (res_take)
    );
endmodule
`default_nettype wire

// ===== sv/scc_checker.sv =====
// port-level checks for the component counter, bound to the top level
`default_nettype none
module scc_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         psel,
    input wire logic                         penable,
    input wire logic                         pwrite,
    input wire logic [scc_pkg::APB_AW-1:0]   paddr,
    input wire logic [scc_pkg::APB_DW-1:0]   prdata,
    input wire logic                         s_valid,
    input wire logic                         s_ready,
    input wire logic                         s_last_edge,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire logic [scc_pkg::FIELD_W-1:0]  m_component_count
);
    // no result pending right after reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // a closing transfer starts the count, no new edge in the next cycle
    a_busy_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_edge |=> !s_ready)
        else $error("input taken right after last transfer");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_component_count))
        else $error("stalled result changed");

    // node_count read back has no bits above the field
    a_rd_width: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && !pwrite && (paddr[2] == scc_pkg::CFG_NODE_COUNT)
        |-> prdata[scc_pkg::APB_DW-1:scc_pkg::FIELD_W] == '0)
        else $error("node_count read back too wide");
endmodule

bind scc_count_kosaraju scc_checker u_scc_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .prdata            (prdata),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .s_last_edge       (s_last_edge),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_component_count (m_component_count)
);
`default_nettype wire

// ===== dv/tb_scc_count_kosaraju.sv =====
// strongly connected component counter testbench: fixed and random graphs, self-checking
`default_nettype none
module tb_scc_count_kosaraju;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES_MAX = 1024;
    localparam int EDGES_MAX = 4096;
    localparam int WATCHDOG = 400000;
    localparam int RANDOM_ITEMS = 1200;

    typedef struct {
        logic                        has_edge;
        logic [scc_pkg::FIELD_W-1:0] src;
        logic [scc_pkg::FIELD_W-1:0] dst;
        logic                        last;
    } edge_item_t;

    typedef struct {
        logic [scc_pkg::FIELD_W-1:0] count;
        logic                        dropped;
    } scc_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [scc_pkg::APB_AW-1:0] paddr = '0;
    logic [scc_pkg::APB_DW-1:0] pwdata = '0;
    logic [scc_pkg::APB_DW-1:0] prdata;
    logic pready;
    logic s_valid = 1'b0, s_ready;
    logic s_has_edge = 1'b0, s_last_edge = 1'b0;
    logic [scc_pkg::FIELD_W-1:0] s_edge_source = '0, s_edge_target = '0;
    logic m_valid, m_ready = 1'b0;
    logic [scc_pkg::FIELD_W-1:0] m_component_count;
    logic m_edge_dropped;

    scc_count_kosaraju u_top (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .s_valid, .s_ready, .s_has_edge, .s_edge_source, .s_edge_target, .s_last_edge,
        .m_valid, .m_ready, .m_component_count, .m_edge_dropped
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    edge_item_t  pending_items[$];
    scc_result_t expected_counts[$];
    int errors = 0;
    int idle_cycles = 0;
    bit quiet = 1'b0;
    bit hold_request = 1'b0;
    bit s_taken = 1'b0;

    // predictor state
    int unsigned node_count_copy = 1;
    int unsigned store_from[$];
    int unsigned store_to[$];
    bit drop_flag = 1'b0;
    int unsigned adj_off[2][0:NODES_MAX];
    int unsigned adj_nbr[2][0:EDGES_MAX-1];
    int unsigned cursor[0:NODES_MAX-1];
    int unsigned stack_node[0:NODES_MAX-1];
    int unsigned stack_cur[0:NODES_MAX-1];
    int unsigned finish_list[0:NODES_MAX-1];
    bit visited[0:NODES_MAX-1];
    int unsigned finished;

    function automatic void build_adjacency(int unsigned n, int d);
        int unsigned k, w, slot;
        for (int unsigned v = 0; v <= n; v++) adj_off[d][v] = 0;
        for (int e = 0; e < store_from.size(); e++) begin
            k = d ? store_to[e] : store_from[e];
            w = d ? store_from[e] : store_to[e];
            if (k < n && w < n) adj_off[d][k+1]++;
        end
        for (int unsigned v = 0; v < n; v++) adj_off[d][v+1] += adj_off[d][v];
        for (int unsigned v = 0; v < n; v++) cursor[v] = adj_off[d][v];
        for (int e = 0; e < store_from.size(); e++) begin
            k = d ? store_to[e] : store_from[e];
            w = d ? store_from[e] : store_to[e];
            if (k < n && w < n) begin
                slot = cursor[k];
                cursor[k]++;
                if (slot < EDGES_MAX) adj_nbr[d][slot] = w;
            end
        end
    endfunction

    function automatic void depth_walk(int unsigned start, int d, bit record);
        int unsigned sp, v, c, w;
        sp = 1;
        visited[start] = 1'b1;
        stack_node[0] = start;
        stack_cur[0] = adj_off[d][start];
        while (sp > 0) begin
            v = stack_node[sp-1];
            c = stack_cur[sp-1];
            if (c < adj_off[d][v+1] && c < EDGES_MAX) begin
                w = adj_nbr[d][c];
                stack_cur[sp-1] = c + 1;
                if (w < NODES_MAX && !visited[w] && sp < NODES_MAX) begin
                    visited[w] = 1'b1;
                    stack_node[sp] = w;
                    stack_cur[sp] = adj_off[d][w];
                    sp++;
                end
            end else begin
                sp--;
                if (record && finished < NODES_MAX) begin
                    finish_list[finished] = v;
                    finished++;
                end
            end
        end
    endfunction

    function automatic int unsigned count_components(int unsigned n);
        int unsigned total, u;
        total = 0;
        build_adjacency(n, 0);
        build_adjacency(n, 1);
        for (int v = 0; v < NODES_MAX; v++) visited[v] = 1'b0;
        finished = 0;
        for (int unsigned v = 0; v < n; v++)
            if (!visited[v]) depth_walk(v, 0, 1'b1);
        for (int v = 0; v < NODES_MAX; v++) visited[v] = 1'b0;
        for (int unsigned i = finished; i > 0; i--) begin
            u = finish_list[i-1];
            if (u < n && !visited[u]) begin
                depth_walk(u, 1, 1'b0);
                total++;
            end
        end
        return total;
    endfunction

    function automatic void predict_item(edge_item_t it);
        int unsigned n, s, t;
        scc_result_t r;
        n = node_count_copy > NODES_MAX ? NODES_MAX : node_count_copy;
        s = it.src;
        t = it.dst;
        if (it.has_edge) begin
            if (s == 0 || t == 0 || s > n || t > n || store_from.size() >= EDGES_MAX) begin
                drop_flag = 1'b1;
            end else begin
                store_from.insert(store_from.size(), s - 1);
                store_to.insert(store_to.size(), t - 1);
            end
        end
        if (it.last) begin
            r.count = scc_pkg::FIELD_W'(count_components(n));
            r.dropped = drop_flag;
            expected_counts.insert(expected_counts.size(), r);
            store_from.delete();
            store_to.delete();
            drop_flag = 1'b0;
        end
    endfunction

    // input driver
    int s_gap = 0;
    always @(negedge aclk) begin
        logic nv;
        edge_item_t it;
        nv = s_valid;
        if (!(s_valid && !s_taken)) begin
            nv = 1'b0;
            if (s_gap > 0) begin
                s_gap--;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                s_gap = $urandom_range(1, 9);
            end else if (pending_items.size() > 0) begin
                it = pending_items.pop_front();
                nv = 1'b1;
                s_has_edge <= it.has_edge;
                s_edge_source <= it.src;
                s_edge_target <= it.dst;
                s_last_edge <= it.last;
            end
        end
        s_valid <= nv;
    end

    // result receiver
    int m_gap = 0;
    int long_hold = 0;
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            long_hold = 4000;
        end
        if (long_hold > 0) begin
            long_hold--;
            m_ready <= 1'b0;
        end else if (m_gap > 0) begin
            m_gap--;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            m_gap = $urandom_range(1, 9);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor, checker and watchdog
    always @(posedge aclk) begin
        edge_item_t it;
        scc_result_t exp_r;
        s_taken <= s_valid && s_ready && aresetn;
        if (aresetn && s_valid && s_ready) begin
            it.has_edge = s_has_edge;
            it.src = s_edge_source;
            it.dst = s_edge_target;
            it.last = s_last_edge;
            predict_item(it);
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_counts.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result transfer: count %0d dropped %0d",
                                           m_component_count, m_edge_dropped);
            end else begin
                exp_r = expected_counts.pop_front();
                if (m_component_count !== exp_r.count) begin
                    errors++;
                    if (errors <= 10) $display("component_count: expected %0d got %0d",
                                               exp_r.count, m_component_count);
                end
                if (m_edge_dropped !== exp_r.dropped) begin
                    errors++;
                    if (errors <= 10) $display("edge_dropped: expected %0d got %0d",
                                               exp_r.dropped, m_edge_dropped);
                end
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic push_item(bit he, int s, int t, bit lst);
        edge_item_t it;
        it.has_edge = he;
        it.src = scc_pkg::FIELD_W'(s);
        it.dst = scc_pkg::FIELD_W'(t);
        it.last = lst;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || s_valid || expected_counts.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_node_count(int unsigned value);
        wait_idle();
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= scc_pkg::APB_DW'(value);
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        node_count_copy = value & 32'h7FF;
    endtask

    initial begin
        int n, ne, span, sent, graphs;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed graphs
        write_node_count(4);
        push_item(1, 1, 2, 0);
        push_item(1, 2, 1, 0);
        push_item(1, 4, 4, 0);
        push_item(1, 0, 1, 0);
        push_item(1, 5, 1, 0);
        push_item(0, 2047, 2047, 0);
        push_item(1, 3, 4, 1);
        write_node_count(1);
        push_item(0, 0, 0, 1);
        push_item(1, 1, 1, 1);
        write_node_count(0);
        push_item(1, 1, 1, 1);
        write_node_count(1024);
        push_item(1, 1024, 1024, 0);
        push_item(1, 1, 1024, 0);
        push_item(1, 1024, 1, 1);
        write_node_count(2047);
        push_item(1, 2047, 1, 0);
        push_item(1, 1024, 1, 1);
        write_node_count(8);
        push_item(1, 8, 1, 0);
        push_item(1, 1, 8, 0);
        push_item(1, 2, 3, 0);
        write_node_count(4);
        push_item(0, 0, 0, 1);

        // random graphs
        sent = 0;
        graphs = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent > RANDOM_ITEMS - 150) quiet = 1'b1;
            if (graphs == 6) begin
                write_node_count(8);
                hold_request = 1'b1;
            end else if ((graphs < 6 || graphs > 9) && $urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 9))
                    0: n = 1024;
                    1: n = 2047;
                    2: n = 0;
                    3: n = $urandom_range(1, 2047);
                    default: n = $urandom_range(1, 12);
                endcase
                write_node_count(n);
            end
            n = node_count_copy > NODES_MAX ? NODES_MAX : node_count_copy;
            span = n < 12 ? n : 12;
            ne = $urandom_range(0, 30);
            for (int i = 0; i < ne; i++) begin
                if ($urandom_range(0, 15) == 0 || span == 0)
                    push_item($urandom_range(0, 1), $urandom_range(0, 2047),
                              $urandom_range(0, 2047), 0);
                else if ($urandom_range(0, 3) == 0)
                    push_item(1, $urandom_range(1, n), $urandom_range(1, n), 0);
                else
                    push_item(1, $urandom_range(1, span), $urandom_range(1, span), 0);
            end
            if ($urandom_range(0, 1) && span > 0)
                push_item(1, $urandom_range(1, span), $urandom_range(1, span), 1);
            else
                push_item(0, $urandom_range(0, 2047), $urandom_range(0, 2047), 1);
            sent += ne + 1;
            graphs++;
            while (pending_items.size() > 64) @(posedge aclk);
        end

        while (pending_items.size() > 0 || s_valid || expected_counts.size() > 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
